/* sv/wavhp_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the wav header parser
package wavhp_pkg;

	// parse phases
	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_LEN  = 3'd1,
		PH_RIFF = 3'd2,
		PH_CHDR = 3'd3,
		PH_FMT  = 3'd4,
		PH_SKIP = 3'd5,
		PH_DATA = 3'd6
	} phase_t;

	// result kinds
	typedef enum logic [1:0] {
		KIND_READY  = 2'd0,
		KIND_SAMPLE = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	// error codes
	typedef enum logic [2:0] {
		ERR_SHORT    = 3'd0,
		ERR_NOT_WAVE = 3'd1,
		ERR_NOT_MONO = 3'd2,
		ERR_RATE     = 3'd3,
		ERR_NOT_8BIT = 3'd4,
		ERR_NO_FMT   = 3'd5,
		ERR_PAST_END = 3'd6
	} err_t;

	// little-endian tags as they sit in the accumulator
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;
	localparam logic [31:0] MIN_LEN  = 32'd40;
	localparam logic [31:0] FMT_LEN  = 32'd16;

	// byte positions inside fields
	localparam logic [3:0] IDX_WORD0_END = 4'd3;
	localparam logic [3:0] IDX_WORD1_END = 4'd7;
	localparam logic [3:0] IDX_RIFF_END  = 4'd11;
	localparam logic [3:0] IDX_BITS_END  = 4'd13;
	localparam logic [3:0] IDX_FMT_END   = 4'd15;

	localparam int TDATA_W = 64;

	// one result transaction
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  sample_value;
		logic [15:0] audio_rate;
		logic [31:0] sample_total;
		err_t        error_code;
		logic        last_sample;
	} res_t;

endpackage

/* sv/wav_header_parser.sv */
`timescale 1ns / 1ps
// top level of the byte-serial wav header parser
//
// channel   direction  tdata                         tuser         tlast
// s_axis    in         data_byte[7:0]                first_byte    -
// m_axis    out        sample_value, audio_rate,     kind[1:0]     last_sample
//                      sample_total, error_code
//
// one byte is taken per cycle while tready is high; its result, if any, is
// registered and shows on m_axis; the parse logic works between the state
// registers and the output register; a two-entry output buffer lets input run
// while a result waits; tready falls only when both entries are full
// arst_n clears the parser to idle and empties the output buffer
module wav_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] first_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] sample_value, [23:8] audio_rate, [55:24] sample_total,
	// [58:56] error_code, [63:59] zero
	output logic [wavhp_pkg::TDATA_W-1:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,  // [1:0] kind
	output logic        m_axis_tlast   // last_sample
);

	logic            in_fire;
	logic            res_valid;
	wavhp_pkg::res_t res;
	wavhp_pkg::res_t out_res;

	assign in_fire = s_axis_tvalid & s_axis_tready;

	// parse core
	wavhp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.data_byte (s_axis_tdata),
		.first_byte(s_axis_tuser),
		.res_valid (res_valid),
		.res       (res)
	);

	// result buffer
	wavhp_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_res (res),
		.pop_ready(m_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_res  (out_res),
		.in_ready (s_axis_tready)
	);

	// pack the master side
	assign m_axis_tdata = {5'd0, out_res.error_code, out_res.sample_total,
	                       out_res.audio_rate, out_res.sample_value};
	assign m_axis_tuser = out_res.kind;
	assign m_axis_tlast = out_res.last_sample;

endmodule

/* sv/wavhp_parse.sv */
`timescale 1ns / 1ps
// parser state registers and per-byte next state and result logic
module wavhp_parse (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_fire,
	input  logic [7:0]      data_byte,
	input  logic            first_byte,
	output logic            res_valid,
	output wavhp_pkg::res_t res
);

	wavhp_pkg::phase_t phase_q, phase_d;
	logic [3:0]  idx_q, idx_d;
	logic [31:0] off_q, off_d;
	logic [31:0] len_q, len_d;
	logic [31:0] tag_q, tag_d;
	logic [31:0] acc_q, acc_d;
	logic [31:0] skip_q, skip_d;
	logic [15:0] rate_q, rate_d;
	logic        fmt_q, fmt_d;
	logic [31:0] left_q, left_d;

	// working values after a possible restart
	wavhp_pkg::phase_t eff_ph;
	logic [3:0]  eff_idx;
	logic [31:0] eff_off;
	logic [31:0] eff_acc;
	logic        eff_fmt;
	logic [15:0] eff_rate;
	logic [31:0] off_n;
	logic [31:0] acc_n;
	logic [31:0] skip_dec;
	logic [31:0] left_dec;
	logic        past_end;

	// event flags
	logic              fail_c;
	wavhp_pkg::err_t   code_c;
	logic              rdy_c;
	logic              smp_c;
	logic              nc_c;

	// restart and byte shift
	always_comb begin
		eff_ph   = first_byte ? wavhp_pkg::PH_LEN : phase_q;
		eff_idx  = first_byte ? 4'd0 : idx_q;
		eff_off  = first_byte ? 32'd0 : off_q;
		eff_acc  = first_byte ? 32'd0 : acc_q;
		eff_fmt  = first_byte ? 1'b0 : fmt_q;
		eff_rate = first_byte ? 16'd0 : rate_q;
		off_n    = eff_off + 32'd1;
		acc_n    = {data_byte, eff_acc[31:8]};
		skip_dec = (skip_q != 32'd0) ? skip_q - 32'd1 : 32'd0;
		left_dec = (left_q != 32'd0) ? left_q - 32'd1 : 32'd0;
		past_end = off_n >= len_q;
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		off_d   = off_q;
		len_d   = len_q;
		tag_d   = tag_q;
		acc_d   = acc_q;
		skip_d  = skip_q;
		rate_d  = rate_q;
		fmt_d   = fmt_q;
		left_d  = left_q;
		fail_c  = 1'b0;
		code_c  = wavhp_pkg::ERR_SHORT;
		rdy_c   = 1'b0;
		smp_c   = 1'b0;
		nc_c    = 1'b0;
		if (in_fire) begin
			phase_d = eff_ph;
			idx_d   = eff_idx;
			off_d   = eff_off;
			acc_d   = eff_acc;
			fmt_d   = eff_fmt;
			rate_d  = eff_rate;
			if (eff_ph != wavhp_pkg::PH_IDLE) begin
				off_d = off_n;
				acc_d = acc_n;
				case (eff_ph)
					wavhp_pkg::PH_LEN: begin
						if (eff_idx < wavhp_pkg::IDX_WORD0_END) begin
							idx_d = eff_idx + 4'd1;
						end else begin
							len_d = acc_n;
							idx_d = 4'd0;
							if (acc_n < wavhp_pkg::MIN_LEN) begin
								fail_c = 1'b1;
								code_c = wavhp_pkg::ERR_SHORT;
							end else begin
								phase_d = wavhp_pkg::PH_RIFF;
							end
						end
					end
					wavhp_pkg::PH_RIFF: begin
						if (eff_idx == wavhp_pkg::IDX_WORD0_END &&
						    acc_n != wavhp_pkg::TAG_RIFF) begin
							fail_c = 1'b1;
							code_c = wavhp_pkg::ERR_NOT_WAVE;
						end else if (eff_idx < wavhp_pkg::IDX_RIFF_END) begin
							idx_d = eff_idx + 4'd1;
						end else if (acc_n != wavhp_pkg::TAG_WAVE) begin
							fail_c = 1'b1;
							code_c = wavhp_pkg::ERR_NOT_WAVE;
						end else begin
							nc_c = 1'b1;
						end
					end
					wavhp_pkg::PH_CHDR: begin
						if (eff_idx == wavhp_pkg::IDX_WORD0_END) begin
							tag_d = acc_n;
						end
						if (eff_idx < wavhp_pkg::IDX_WORD1_END) begin
							idx_d = eff_idx + 4'd1;
						end else begin
							idx_d = 4'd0;
							if (tag_q == wavhp_pkg::TAG_FMT) begin
								skip_d  = (acc_n > wavhp_pkg::FMT_LEN) ?
								          acc_n - wavhp_pkg::FMT_LEN : 32'd0;
								phase_d = wavhp_pkg::PH_FMT;
							end else if (tag_q == wavhp_pkg::TAG_DATA) begin
								if (!eff_fmt) begin
									fail_c = 1'b1;
									code_c = wavhp_pkg::ERR_NO_FMT;
								end else begin
									left_d  = acc_n;
									rdy_c   = 1'b1;
									phase_d = (acc_n != 32'd0) ? wavhp_pkg::PH_DATA :
									          wavhp_pkg::PH_IDLE;
								end
							end else begin
								skip_d = acc_n;
								if (acc_n == 32'd0) begin
									nc_c = 1'b1;
								end else begin
									phase_d = wavhp_pkg::PH_SKIP;
								end
							end
						end
					end
					wavhp_pkg::PH_FMT: begin
						if (eff_idx == wavhp_pkg::IDX_WORD0_END &&
						    acc_n[31:16] != 16'd1) begin
							fail_c = 1'b1;
							code_c = wavhp_pkg::ERR_NOT_MONO;
						end else if (eff_idx == wavhp_pkg::IDX_WORD1_END &&
						             acc_n[31:16] != 16'd0) begin
							fail_c = 1'b1;
							code_c = wavhp_pkg::ERR_RATE;
						end else if (eff_idx == wavhp_pkg::IDX_BITS_END &&
						             acc_n[31:16] != 16'd1) begin
							fail_c = 1'b1;
							code_c = wavhp_pkg::ERR_NOT_8BIT;
						end else begin
							if (eff_idx == wavhp_pkg::IDX_WORD1_END) begin
								rate_d = acc_n[15:0];
							end
							if (eff_idx < wavhp_pkg::IDX_FMT_END) begin
								idx_d = eff_idx + 4'd1;
							end else begin
								fmt_d = 1'b1;
								idx_d = 4'd0;
								if (skip_q != 32'd0) begin
									phase_d = wavhp_pkg::PH_SKIP;
								end else begin
									nc_c = 1'b1;
								end
							end
						end
					end
					wavhp_pkg::PH_SKIP: begin
						skip_d = skip_dec;
						if (skip_dec == 32'd0) begin
							nc_c = 1'b1;
						end
					end
					wavhp_pkg::PH_DATA: begin
						left_d = left_dec;
						smp_c  = 1'b1;
						if (left_dec == 32'd0) begin
							phase_d = wavhp_pkg::PH_IDLE;
						end
					end
					default: begin
						phase_d = wavhp_pkg::PH_IDLE;
					end
				endcase
				// end test where a chunk header would begin
				if (nc_c) begin
					idx_d = 4'd0;
					if (past_end) begin
						fail_c = 1'b1;
						code_c = wavhp_pkg::ERR_PAST_END;
					end else begin
						phase_d = wavhp_pkg::PH_CHDR;
					end
				end
				if (fail_c) begin
					phase_d = wavhp_pkg::PH_IDLE;
					idx_d   = 4'd0;
				end
			end
		end
	end

	// result transaction
	always_comb begin
		res_valid        = fail_c | rdy_c | smp_c;
		res.kind         = wavhp_pkg::KIND_READY;
		res.sample_value = 8'd0;
		res.audio_rate   = 16'd0;
		res.sample_total = 32'd0;
		res.error_code   = wavhp_pkg::ERR_SHORT;
		res.last_sample  = 1'b0;
		if (fail_c) begin
			res.kind       = wavhp_pkg::KIND_ERROR;
			res.error_code = code_c;
		end else if (rdy_c) begin
			res.audio_rate   = eff_rate;
			res.sample_total = acc_n;
			res.last_sample  = (acc_n == 32'd0);
		end else if (smp_c) begin
			res.kind         = wavhp_pkg::KIND_SAMPLE;
			res.sample_value = data_byte;
			res.last_sample  = (left_dec == 32'd0);
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wavhp_pkg::PH_IDLE;
			idx_q   <= 4'd0;
			off_q   <= 32'd0;
			len_q   <= 32'd0;
			tag_q   <= 32'd0;
			acc_q   <= 32'd0;
			skip_q  <= 32'd0;
			rate_q  <= 16'd0;
			fmt_q   <= 1'b0;
			left_q  <= 32'd0;
		end else begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			off_q   <= off_d;
			len_q   <= len_d;
			tag_q   <= tag_d;
			acc_q   <= acc_d;
			skip_q  <= skip_d;
			rate_q  <= rate_d;
			fmt_q   <= fmt_d;
			left_q  <= left_d;
		end
	end

	// a result only comes from an accepted byte
	a_res_needs_fire: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> in_fire)
		else $error("result without accepted byte");

	// samples come only out of the data phase
	a_sample_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == wavhp_pkg::KIND_SAMPLE |-> phase_q == wavhp_pkg::PH_DATA)
		else $error("sample outside data phase");

	// an error leaves the parser idle
	a_error_idles: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == wavhp_pkg::KIND_ERROR |=> phase_q == wavhp_pkg::PH_IDLE)
		else $error("parser not idle after error");

	// ready with a zero count leaves the parser idle, otherwise in data
	a_ready_next: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == wavhp_pkg::KIND_READY |=>
		(phase_q == wavhp_pkg::PH_DATA) == ($past(res.sample_total) != 32'd0))
		else $error("wrong phase after ready");

endmodule

/* sv/wavhp_out_buf.sv */
`timescale 1ns / 1ps
// output register with skid stage for result transactions
module wavhp_out_buf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  wavhp_pkg::res_t push_res,
	input  logic            pop_ready,
	output logic            out_valid,
	output wavhp_pkg::res_t out_res,
	output logic            in_ready
);

	logic            main_vld_q;
	logic            skid_vld_q;
	wavhp_pkg::res_t main_q;
	wavhp_pkg::res_t skid_q;
	logic            pop;

	assign pop       = main_vld_q & pop_ready;
	assign out_valid = main_vld_q;
	assign out_res   = main_q;
	assign in_ready  = ~skid_vld_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (pop) begin
			if (skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else begin
				main_vld_q <= push;
			end
		end else if (push) begin
			if (main_vld_q) begin
				skid_vld_q <= 1'b1;
			end else begin
				main_vld_q <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_vld_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_res;
			end
		end else if (push) begin
			if (main_vld_q) begin
				skid_q <= push_res;
			end else begin
				main_q <= push_res;
			end
		end
	end

	// skid entry only behind a full output register
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> main_vld_q)
		else $error("skid holds data with empty output register");

	// a stalled push never overwrites the skid entry
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> !push)
		else $error("push into full buffer");

endmodule
